### hdl/hsrp_pkg.sv
// ----------------------------------------------------------------------------
// hsrp_pkg
// Types and constants shared by the HSRP packet classifier modules.
// ----------------------------------------------------------------------------
package hsrp_pkg;

	// field limits and codes
	localparam logic [15:0] V1_LAST_INDEX   = 16'd19;
	localparam logic [15:0] V1_MAX_LENGTH   = 16'd20;
	localparam logic [7:0]  V1_OPCODE_MAX   = 8'd3;
	localparam logic [7:0]  TLV_TYPE_MIN    = 8'd1;
	localparam logic [7:0]  TLV_TYPE_MAX    = 8'd4;
	localparam logic [7:0]  TLV_GROUP_STATE = 8'd1;
	localparam logic [7:0]  GS_MIN_LENGTH   = 8'd24;
	localparam logic [7:0]  GS_V4_LENGTH    = 8'd28;
	localparam logic [7:0]  IP_VERSION_4    = 8'd4;
	localparam logic [7:0]  IP_VERSION_6    = 8'd6;
	localparam logic [7:0]  MAX_TLVS_RESET  = 8'd50;

	localparam logic [1:0]  KIND_NONE = 2'd0;
	localparam logic [1:0]  KIND_V1   = 2'd1;
	localparam logic [1:0]  KIND_V2   = 2'd2;

	localparam logic [1:0]  ADDR_NONE = 2'd0;
	localparam logic [1:0]  ADDR_IPV4 = 2'd1;
	localparam logic [1:0]  ADDR_IPV6 = 2'd2;

	// tlv walker phase
	typedef enum logic [1:0] {
		PH_TYPE  = 2'd0,
		PH_LEN   = 2'd1,
		PH_VALUE = 2'd2,
		PH_STOP  = 2'd3
	} tlv_phase_t;

	// input byte request
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	// classification result
	typedef struct packed {
		logic [1:0]  packet_kind;
		logic [7:0]  opcode;
		logic [7:0]  router_state;
		logic [31:0] priority_res;
		logic [15:0] group_number;
		logic [31:0] hello_time;
		logic [31:0] hold_time;
		logic [31:0] virtual_ip;
		logic [1:0]  address_kind;
		logic [63:0] auth_text;
		logic [7:0]  tlv_count;
		logic        tlvs_capped;
	} result_item_t;

	// per-byte strobe to the parsers
	typedef struct packed {
		logic       step;
		logic       last;
		logic [7:0] data_byte;
	} byte_step_t;

	// version 1 verdict after the current byte
	typedef struct packed {
		logic        hit;
		logic [7:0]  opcode;
		logic [7:0]  router_state;
		logic [7:0]  hello_time;
		logic [7:0]  hold_time;
		logic [7:0]  priority_res;
		logic [7:0]  group_number;
		logic [63:0] auth_text;
		logic [31:0] virtual_ip;
	} v1_status_t;

	// version 2 verdict after the current byte
	typedef struct packed {
		logic        hit;
		logic [7:0]  opcode;
		logic [7:0]  router_state;
		logic [31:0] priority_res;
		logic [15:0] group_number;
		logic [31:0] hello_time;
		logic [31:0] hold_time;
		logic [31:0] virtual_ip;
		logic [1:0]  address_kind;
		logic [7:0]  tlv_count;
		logic        tlvs_capped;
	} v2_status_t;

endpackage

### hdl/hsrp_packet_classifier.sv
// ----------------------------------------------------------------------------
// hsrp_packet_classifier
// Classifies a UDP payload as HSRP version 1, version 2 or neither.
// ----------------------------------------------------------------------------
// The block takes one payload byte per cycle, unless a last byte is held
// back, and returns one result for each payload. A byte is first held in
// the input register; the version 1 and version 2 parsers then update their
// state from it in a single pass, and on the last byte their verdict is
// loaded into the result register. The input register frees whenever its
// byte steps on, so bytes stream back to back at one per cycle; only a last
// byte waits while an earlier result is still held. The max_tlvs register
// resets to 50; it is to be written through the cfg channel only while no
// packet is in progress, which the block itself does not enforce.
module hsrp_packet_classifier (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  hsrp_pkg::byte_item_t    byte_data,
	output logic                    result_valid,
	input  logic                    result_stall,
	output hsrp_pkg::result_item_t  result_data,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [7:0]              cfg_data
);

	logic                  valid_s1;
	hsrp_pkg::byte_item_t  item_s1;
	logic [15:0]           index_q;
	logic [7:0]            max_tlvs_q;
	logic                  out_free;
	logic                  advance;
	logic                  step;
	hsrp_pkg::byte_step_t  step_req;
	hsrp_pkg::v1_status_t  v1_stat;
	hsrp_pkg::v2_status_t  v2_stat;
	hsrp_pkg::result_item_t verdict;

	// flow control
	assign out_free   = !result_valid || !result_stall;
	assign advance    = !item_s1.last_byte || out_free;
	assign step       = valid_s1 && advance;
	assign byte_stall = valid_s1 && !advance;
	assign cfg_ready  = 1'b1;

	assign step_req.step      = step;
	assign step_req.last      = item_s1.last_byte;
	assign step_req.data_byte = item_s1.data_byte;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_tlvs_q <= hsrp_pkg::MAX_TLVS_RESET;
		else if (cfg_valid && cfg_ready) max_tlvs_q <= cfg_data;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) item_s1 <= byte_data;
	end

	// byte position in the payload, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
		end else if (step) begin
			if (item_s1.last_byte) index_q <= '0;
			else if (index_q != 16'hFFFF) index_q <= index_q + 16'd1;
		end
	end

	hsrp_v1_parser u_v1 (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (step_req),
		.byte_index (index_q),
		.status     (v1_stat)
	);

	hsrp_v2_parser u_v2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (step_req),
		.max_tlvs (max_tlvs_q),
		.status   (v2_stat)
	);

	// verdict selection, version 1 first
	always_comb begin
		verdict = '0;
		if (v1_stat.hit) begin
			verdict.packet_kind  = hsrp_pkg::KIND_V1;
			verdict.opcode       = v1_stat.opcode;
			verdict.router_state = v1_stat.router_state;
			verdict.priority_res = {24'd0, v1_stat.priority_res};
			verdict.group_number = {8'd0, v1_stat.group_number};
			verdict.hello_time   = {24'd0, v1_stat.hello_time};
			verdict.hold_time    = {24'd0, v1_stat.hold_time};
			verdict.virtual_ip   = v1_stat.virtual_ip;
			verdict.address_kind = hsrp_pkg::ADDR_IPV4;
			verdict.auth_text    = v1_stat.auth_text;
		end else if (v2_stat.hit) begin
			verdict.packet_kind  = hsrp_pkg::KIND_V2;
			verdict.opcode       = v2_stat.opcode;
			verdict.router_state = v2_stat.router_state;
			verdict.priority_res = v2_stat.priority_res;
			verdict.group_number = v2_stat.group_number;
			verdict.hello_time   = v2_stat.hello_time;
			verdict.hold_time    = v2_stat.hold_time;
			verdict.virtual_ip   = v2_stat.virtual_ip;
			verdict.address_kind = v2_stat.address_kind;
			verdict.tlv_count    = v2_stat.tlv_count;
			verdict.tlvs_capped  = v2_stat.tlvs_capped;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (step && item_s1.last_byte) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && item_s1.last_byte) result_data <= verdict;
	end

	// a new result appears only after a last byte went through the parsers
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(step && item_s1.last_byte))
		else $error("result without a last byte");

	// a held result blocks a waiting last byte
	a_last_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall && valid_s1 && item_s1.last_byte) |-> !step)
		else $error("last byte overran a held result");

	// a version 1 verdict always carries an ipv4 address kind and no tlv count
	a_v1_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_data.packet_kind == hsrp_pkg::KIND_V1)
		|-> (result_data.address_kind == hsrp_pkg::ADDR_IPV4 &&
		     result_data.tlv_count == 8'd0 && !result_data.tlvs_capped))
		else $error("malformed version 1 result");

	// byte position resets after each packet
	a_index_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.last_byte) |=> index_q == 16'd0)
		else $error("byte index not cleared");

endmodule

### hdl/hsrp_v1_parser.sv
// ----------------------------------------------------------------------------
// hsrp_v1_parser
// Checks and captures the fixed 20-byte version 1 layout, one byte per step.
// ----------------------------------------------------------------------------
module hsrp_v1_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hsrp_pkg::byte_step_t  byte_in,
	input  logic [15:0]           byte_index,
	output hsrp_pkg::v1_status_t  status
);

	logic        valid_q, valid_n;
	logic [7:0]  opcode_q, opcode_n;
	logic [7:0]  state_q, state_n;
	logic [7:0]  hello_q, hello_n;
	logic [7:0]  hold_q, hold_n;
	logic [7:0]  prio_q, prio_n;
	logic [7:0]  group_q, group_n;
	logic [63:0] auth_q, auth_n;
	logic [31:0] addr_q, addr_n;
	logic [7:0]  b;

	assign b = byte_in.data_byte;

	// header checks and field capture for this byte
	always_comb begin
		valid_n  = valid_q;
		opcode_n = opcode_q;
		state_n  = state_q;
		hello_n  = hello_q;
		hold_n   = hold_q;
		prio_n   = prio_q;
		group_n  = group_q;
		auth_n   = auth_q;
		addr_n   = addr_q;
		if (byte_index == 16'd0 && b != 8'd0) valid_n = 1'b0;
		if (byte_index == 16'd1 && b > hsrp_pkg::V1_OPCODE_MAX) valid_n = 1'b0;
		if (byte_index == 16'd2 && !(b inside {8'd0, 8'd1, 8'd2, 8'd4, 8'd8, 8'd16}))
			valid_n = 1'b0;
		if (byte_index >= hsrp_pkg::V1_MAX_LENGTH) valid_n = 1'b0;
		case (byte_index)
			16'd1: opcode_n = b;
			16'd2: state_n  = b;
			16'd3: hello_n  = b;
			16'd4: hold_n   = b;
			16'd5: prio_n   = b;
			16'd6: group_n  = b;
			default: ;
		endcase
		// bytes arrive in order, so shifting in leaves the first byte on top
		if (byte_index inside {[16'd8:16'd15]}) auth_n = {auth_q[55:0], b};
		if (byte_index inside {[16'd16:16'd19]}) addr_n = {addr_q[23:0], b};
	end

	// verdict including the current byte
	always_comb begin
		status.hit          = valid_n && (byte_index == hsrp_pkg::V1_LAST_INDEX);
		status.opcode       = opcode_n;
		status.router_state = state_n;
		status.hello_time   = hello_n;
		status.hold_time    = hold_n;
		status.priority_res = prio_n;
		status.group_number = group_n;
		status.auth_text    = auth_n;
		status.virtual_ip   = addr_n;
	end

	// per-packet state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b1;
			opcode_q <= '0;
			state_q  <= '0;
			hello_q  <= '0;
			hold_q   <= '0;
			prio_q   <= '0;
			group_q  <= '0;
			auth_q   <= '0;
			addr_q   <= '0;
		end else if (byte_in.step) begin
			if (byte_in.last) begin
				valid_q  <= 1'b1;
				opcode_q <= '0;
				state_q  <= '0;
				hello_q  <= '0;
				hold_q   <= '0;
				prio_q   <= '0;
				group_q  <= '0;
				auth_q   <= '0;
				addr_q   <= '0;
			end else begin
				valid_q  <= valid_n;
				opcode_q <= opcode_n;
				state_q  <= state_n;
				hello_q  <= hello_n;
				hold_q   <= hold_n;
				prio_q   <= prio_n;
				group_q  <= group_n;
				auth_q   <= auth_n;
				addr_q   <= addr_n;
			end
		end
	end

endmodule

### hdl/hsrp_v2_parser.sv
// ----------------------------------------------------------------------------
// hsrp_v2_parser
// Walks the version 2 type/length/value chain and captures the first
// decodable group state item.
// ----------------------------------------------------------------------------
module hsrp_v2_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hsrp_pkg::byte_step_t  byte_in,
	input  logic [7:0]            max_tlvs,
	output hsrp_pkg::v2_status_t  status
);

	hsrp_pkg::tlv_phase_t phase_q, phase_n;
	logic [7:0]  type_q, type_n;
	logic [7:0]  len_q, len_n;
	logic [7:0]  offset_q, offset_n;
	logic [7:0]  first_q, first_n;
	logic [7:0]  count_q, count_n;
	logic        failed_q, failed_n;
	logic        capped_q, capped_n;
	logic        found_q, found_n;
	logic [7:0]  opcode_q, opcode_n;
	logic [7:0]  state_q, state_n;
	logic [7:0]  ipver_q, ipver_n;
	logic [15:0] group_q, group_n;
	logic [31:0] hello_q, hello_n;
	logic [31:0] hold_q, hold_n;
	logic [31:0] prio_q, prio_n;
	logic [31:0] addr_q, addr_n;
	logic [7:0]  b;
	logic        finish;
	logic [1:0]  lane;

	assign b    = byte_in.data_byte;
	// value bytes of each 32-bit field start on a multiple of four, msb first
	assign lane = ~offset_q[1:0];

	// chain walker for this byte
	always_comb begin
		phase_n  = phase_q;
		type_n   = type_q;
		len_n    = len_q;
		offset_n = offset_q;
		first_n  = first_q;
		count_n  = count_q;
		failed_n = failed_q;
		capped_n = capped_q;
		found_n  = found_q;
		opcode_n = opcode_q;
		state_n  = state_q;
		ipver_n  = ipver_q;
		group_n  = group_q;
		hello_n  = hello_q;
		hold_n   = hold_q;
		prio_n   = prio_q;
		addr_n   = addr_q;
		finish   = 1'b0;
		if (!failed_q) begin
			case (phase_q)
				hsrp_pkg::PH_STOP: begin
					capped_n = 1'b1;
				end
				hsrp_pkg::PH_TYPE: begin
					type_n = b;
					if (count_q == 8'd0) begin
						first_n = b;
						if (!(b inside {[hsrp_pkg::TLV_TYPE_MIN:hsrp_pkg::TLV_TYPE_MAX]}))
							failed_n = 1'b1;
					end
					if (!found_q) begin
						opcode_n = '0;
						state_n  = '0;
						ipver_n  = '0;
						group_n  = '0;
						hello_n  = '0;
						hold_n   = '0;
						prio_n   = '0;
						addr_n   = '0;
					end
					phase_n = hsrp_pkg::PH_LEN;
				end
				hsrp_pkg::PH_LEN: begin
					len_n    = b;
					offset_n = '0;
					if (b == 8'd0) finish = 1'b1;
					else phase_n = hsrp_pkg::PH_VALUE;
				end
				hsrp_pkg::PH_VALUE: begin
					if (type_q == hsrp_pkg::TLV_GROUP_STATE && !found_q) begin
						case (offset_q) inside
							8'd1: opcode_n = b;
							8'd2: state_n  = b;
							8'd3: ipver_n  = b;
							8'd4: group_n[15:8] = b;
							8'd5: group_n[7:0]  = b;
							[8'd12:8'd15]: prio_n[{lane, 3'b000} +: 8]  = b;
							[8'd16:8'd19]: hello_n[{lane, 3'b000} +: 8] = b;
							[8'd20:8'd23]: hold_n[{lane, 3'b000} +: 8]  = b;
							[8'd24:8'd27]: addr_n[{lane, 3'b000} +: 8]  = b;
							default: ;
						endcase
					end
					offset_n = offset_q + 8'd1;
					if (offset_n >= len_q) finish = 1'b1;
				end
				default: ;
			endcase
		end
		// item complete: check for a decodable group state, count it
		if (finish) begin
			if (type_n == hsrp_pkg::TLV_GROUP_STATE && len_n >= hsrp_pkg::GS_MIN_LENGTH &&
			    !found_q &&
			    ((ipver_n == hsrp_pkg::IP_VERSION_4 && len_n >= hsrp_pkg::GS_V4_LENGTH) ||
			     ipver_n == hsrp_pkg::IP_VERSION_6))
				found_n = 1'b1;
			count_n = count_q + 8'd1;
			phase_n = (count_n >= max_tlvs) ? hsrp_pkg::PH_STOP : hsrp_pkg::PH_TYPE;
		end
	end

	// verdict including the current byte
	always_comb begin
		status.hit = !failed_n &&
		             (phase_n == hsrp_pkg::PH_TYPE || phase_n == hsrp_pkg::PH_STOP) &&
		             (first_n inside {[hsrp_pkg::TLV_TYPE_MIN:hsrp_pkg::TLV_TYPE_MAX]});
		status.opcode       = '0;
		status.router_state = '0;
		status.priority_res = '0;
		status.group_number = '0;
		status.hello_time   = '0;
		status.hold_time    = '0;
		status.virtual_ip   = '0;
		status.address_kind = hsrp_pkg::ADDR_NONE;
		status.tlv_count    = count_n;
		status.tlvs_capped  = capped_n;
		if (found_n) begin
			status.opcode       = opcode_n;
			status.router_state = state_n;
			status.priority_res = prio_n;
			status.group_number = group_n;
			status.hello_time   = hello_n;
			status.hold_time    = hold_n;
			if (ipver_n == hsrp_pkg::IP_VERSION_4) begin
				status.virtual_ip   = addr_n;
				status.address_kind = hsrp_pkg::ADDR_IPV4;
			end else begin
				status.address_kind = hsrp_pkg::ADDR_IPV6;
			end
		end
	end

	// per-packet state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= hsrp_pkg::PH_TYPE;
			type_q   <= '0;
			len_q    <= '0;
			offset_q <= '0;
			first_q  <= '0;
			count_q  <= '0;
			failed_q <= 1'b0;
			capped_q <= 1'b0;
			found_q  <= 1'b0;
			opcode_q <= '0;
			state_q  <= '0;
			ipver_q  <= '0;
			group_q  <= '0;
			hello_q  <= '0;
			hold_q   <= '0;
			prio_q   <= '0;
			addr_q   <= '0;
		end else if (byte_in.step) begin
			if (byte_in.last) begin
				phase_q  <= hsrp_pkg::PH_TYPE;
				type_q   <= '0;
				len_q    <= '0;
				offset_q <= '0;
				first_q  <= '0;
				count_q  <= '0;
				failed_q <= 1'b0;
				capped_q <= 1'b0;
				found_q  <= 1'b0;
				opcode_q <= '0;
				state_q  <= '0;
				ipver_q  <= '0;
				group_q  <= '0;
				hello_q  <= '0;
				hold_q   <= '0;
				prio_q   <= '0;
				addr_q   <= '0;
			end else begin
				phase_q  <= phase_n;
				type_q   <= type_n;
				len_q    <= len_n;
				offset_q <= offset_n;
				first_q  <= first_n;
				count_q  <= count_n;
				failed_q <= failed_n;
				capped_q <= capped_n;
				found_q  <= found_n;
				opcode_q <= opcode_n;
				state_q  <= state_n;
				ipver_q  <= ipver_n;
				group_q  <= group_n;
				hello_q  <= hello_n;
				hold_q   <= hold_n;
				prio_q   <= prio_n;
				addr_q   <= addr_n;
			end
		end
	end

	// once stopped, the walker never leaves the stopped phase inside a packet
	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_in.step && !byte_in.last && !failed_q && phase_q == hsrp_pkg::PH_STOP)
		|=> phase_q == hsrp_pkg::PH_STOP)
		else $error("tlv walker left stopped phase");

	// the last byte returns the walker to its idle state
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_in.step && byte_in.last)
		|=> (phase_q == hsrp_pkg::PH_TYPE && count_q == 8'd0 && !failed_q && !found_q))
		else $error("tlv walker not cleared after last byte");

endmodule
